// ----- rtl/pjs_pkg.sv -----
// Package: types, codes and constants of the job scheduler.
package pjs_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam logic [7:0] PRIO_NEVER = 8'hFF;

	typedef enum logic [3:0] {
		REQ_TICK   = 4'd0,
		REQ_ENQ    = 4'd1,
		REQ_REMOVE = 4'd2,
		REQ_START  = 4'd3,
		REQ_PAUSE  = 4'd4,
		REQ_RESUME = 4'd5,
		REQ_STOP   = 4'd6,
		REQ_SKIP   = 4'd7,
		REQ_ABORT  = 4'd8,
		REQ_CLEAR  = 4'd9
	} req_t;

	localparam logic [2:0] JS_PENDING = 3'd0;
	localparam logic [2:0] JS_RUNNING = 3'd1;
	localparam logic [2:0] JS_DONE    = 3'd2;
	localparam logic [2:0] JS_SKIPPED = 3'd3;
	localparam logic [2:0] JS_FAULTED = 3'd4;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_RUNNING = 2'd1;
	localparam logic [1:0] MODE_HOLDING = 2'd2;
	localparam logic [1:0] MODE_STOPPED = 2'd3;

	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_FAULT    = 2'd2;

	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_LAUNCH   = 4'd1;
	localparam logic [3:0] EV_LFAULT   = 4'd2;
	localparam logic [3:0] EV_REARM    = 4'd3;
	localparam logic [3:0] EV_DONE     = 4'd4;
	localparam logic [3:0] EV_IFAULT   = 4'd5;
	localparam logic [3:0] EV_DRAINED  = 4'd6;
	localparam logic [3:0] EV_HOLD     = 4'd7;
	localparam logic [3:0] EV_RFDONE   = 4'd8;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [3:0]  job_index;
		logic [7:0]  job_priority;
		logic [15:0] job_repeat;
		logic [2:0]  job_initial_state;
		logic [1:0]  interp_status;
		logic        launch_ok;
		logic        rearm_ok;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  result_index;
		logic [3:0]  tick_event;
		logic [1:0]  sched_state;
		logic        active_valid;
		logic [3:0]  active_index;
		logic [4:0]  job_total;
	} out_item_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_EXEC,
		C_SCAN,
		C_PICK,
		C_OUT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_start;
		logic scan_step;
		logic pick;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} sts_t;

endpackage

// ----- rtl/priority_job_scheduler.sv -----
// Top level of the priority job scheduler.
// Requests enter on the in channel (in_valid/in_ready, payload in_data) and
// one result per request leaves on the out channel (out_valid/out_ready,
// payload out_data). One request is worked on at a time.
// A non-tick request, or a tick with an active job or a scheduler that is
// not running, is executed and its result loaded into the output register.
// A tick that must pick a job scans the table one entry per cycle, since the
// table is read once per cycle, and then makes its pick. The next request is
// taken in the cycle after the result is loaded into the output register.
// Reset empties the table, clears the active job and sets the mode to idle;
// no clearing pass follows, requests are taken right away.
// When the receiver stalls, the result holds in the output register and a
// following request waits in the controller until that result is taken.
module priority_job_scheduler #(
	parameter int TABLE_DEPTH = pjs_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pjs_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pjs_pkg::out_item_t out_data
);

	pjs_pkg::cmd_t cmd;
	pjs_pkg::sts_t sts;

	pjs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	pjs_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
		.out_data(out_data)
	);

endmodule

// ----- rtl/pjs_ctrl.sv -----
// Controller: sequences request decode, table scan and result hand-off.
module pjs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pjs_pkg::sts_t  sts,
	output pjs_pkg::cmd_t  cmd
);

	pjs_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pjs_pkg::C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == pjs_pkg::C_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		unique case (state_q)
			pjs_pkg::C_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = pjs_pkg::C_EXEC;
				end
			end
			pjs_pkg::C_EXEC: begin
				if (sts.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d = pjs_pkg::C_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d = pjs_pkg::C_OUT;
				end
			end
			pjs_pkg::C_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = pjs_pkg::C_PICK;
			end
			pjs_pkg::C_PICK: begin
				cmd.pick = 1'b1;
				state_d = pjs_pkg::C_OUT;
			end
			pjs_pkg::C_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = pjs_pkg::C_IDLE;
				end
			end
			default: state_d = pjs_pkg::C_IDLE;
		endcase
	end

endmodule

// ----- rtl/pjs_dp.sv -----
// Datapath: job table, scheduler mode, active job and priority scan.
module pjs_dp #(
	parameter int TABLE_DEPTH = pjs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pjs_pkg::in_item_t   in_data,
	input  pjs_pkg::cmd_t       cmd,
	output pjs_pkg::sts_t       sts,
	output pjs_pkg::out_item_t  out_data
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	pjs_pkg::in_item_t req_q;
	logic [TABLE_DEPTH-1:0] used_q;
	logic [2:0]  state_q [TABLE_DEPTH];
	logic [7:0]  prio_q  [TABLE_DEPTH];
	logic [15:0] rep_q   [TABLE_DEPTH];
	logic [15:0] comp_q  [TABLE_DEPTH];
	logic [CW-1:0] alloc_q;
	logic          act_on_q;
	logic [IW-1:0] act_q;
	logic [1:0]    mode_q;

	logic [IW-1:0] scan_q, pick_q;
	logic [7:0]    best_q;
	logic          found_q;

	logic          ok_q;
	logic [IW-1:0] idx_q;
	logic [3:0]    ev_q;
	pjs_pkg::out_item_t out_q;

	logic act_live, is_tick;
	logic [CW-1:0] act_ext, jidx_ext, scan_ext;
	logic [IW-1:0] jidx;
	logic [15:0] comp_inc;
	logic [2:0]  enq_st;

	assign act_ext  = CW'(act_q);
	assign act_live = act_on_q && (act_ext < alloc_q);
	assign is_tick  = (req_q.req_type == pjs_pkg::REQ_TICK);
	assign jidx     = IW'(req_q.job_index);
	assign jidx_ext = CW'(req_q.job_index);
	assign scan_ext = CW'(scan_q);
	assign sts.need_scan = is_tick && !act_live && (mode_q == pjs_pkg::MODE_RUNNING);
	assign sts.scan_last = (scan_q == IW'(TABLE_DEPTH - 1));

	assign comp_inc = (comp_q[act_q] != 16'hFFFF) ? comp_q[act_q] + 16'd1 : comp_q[act_q];
	always_comb begin
		enq_st = req_q.job_initial_state;
		if (enq_st != pjs_pkg::JS_RUNNING && enq_st != pjs_pkg::JS_FAULTED)
			enq_st = pjs_pkg::JS_PENDING;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= in_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && req_q.req_type == pjs_pkg::REQ_ENQ && alloc_q < CW'(TABLE_DEPTH)) begin
			prio_q[alloc_q[IW-1:0]] <= req_q.job_priority;
			rep_q[alloc_q[IW-1:0]]  <= req_q.job_repeat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_q  <= '0;
			found_q <= 1'b0;
			best_q  <= pjs_pkg::PRIO_NEVER;
			pick_q  <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + IW'(1);
			if (scan_ext < alloc_q && used_q[scan_q] && state_q[scan_q] == pjs_pkg::JS_PENDING
					&& prio_q[scan_q] < best_q) begin
				best_q  <= prio_q[scan_q];
				pick_q  <= scan_q;
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			alloc_q  <= '0;
			act_on_q <= 1'b0;
			act_q    <= '0;
			mode_q   <= pjs_pkg::MODE_IDLE;
			ok_q     <= 1'b0;
			idx_q    <= '0;
			ev_q     <= pjs_pkg::EV_NONE;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				state_q[i] <= pjs_pkg::JS_PENDING;
				comp_q[i]  <= '0;
			end
		end else if (cmd.pick) begin
			ok_q <= 1'b1;
			if (!found_q) begin
				mode_q <= pjs_pkg::MODE_IDLE;
				act_on_q <= 1'b0;
				idx_q <= '0;
				ev_q <= pjs_pkg::EV_DRAINED;
			end else begin
				idx_q <= pick_q;
				if (req_q.launch_ok) begin
					state_q[pick_q] <= pjs_pkg::JS_RUNNING;
					act_on_q <= 1'b1;
					act_q <= pick_q;
					ev_q <= pjs_pkg::EV_LAUNCH;
				end else begin
					state_q[pick_q] <= pjs_pkg::JS_FAULTED;
					act_on_q <= 1'b0;
					ev_q <= pjs_pkg::EV_LFAULT;
				end
			end
		end else if (cmd.exec) begin
			ok_q  <= 1'b0;
			idx_q <= '0;
			ev_q  <= pjs_pkg::EV_NONE;
			case (req_q.req_type)
				pjs_pkg::REQ_TICK: begin
					ok_q <= 1'b1;
					if (act_live) begin
						idx_q <= act_q;
						if (req_q.interp_status == pjs_pkg::ST_COMPLETE) begin
							comp_q[act_q] <= comp_inc;
							if ((rep_q[act_q] == 16'd0 || comp_inc < rep_q[act_q])
									&& req_q.rearm_ok) begin
								ev_q <= pjs_pkg::EV_REARM;
							end else begin
								ev_q <= (rep_q[act_q] == 16'd0 || comp_inc < rep_q[act_q])
									? pjs_pkg::EV_RFDONE : pjs_pkg::EV_DONE;
								state_q[act_q] <= pjs_pkg::JS_DONE;
								act_on_q <= 1'b0;
							end
						end else if (req_q.interp_status == pjs_pkg::ST_FAULT) begin
							state_q[act_q] <= pjs_pkg::JS_FAULTED;
							act_on_q <= 1'b0;
							mode_q <= pjs_pkg::MODE_HOLDING;
							ev_q <= pjs_pkg::EV_IFAULT;
						end
					end else begin
						act_on_q <= 1'b0;
						if (mode_q == pjs_pkg::MODE_HOLDING) begin
							mode_q <= pjs_pkg::MODE_IDLE;
							ev_q <= pjs_pkg::EV_HOLD;
						end
					end
				end
				pjs_pkg::REQ_ENQ: begin
					if (alloc_q < CW'(TABLE_DEPTH)) begin
						used_q[alloc_q[IW-1:0]]  <= 1'b1;
						state_q[alloc_q[IW-1:0]] <= enq_st;
						comp_q[alloc_q[IW-1:0]]  <= '0;
						alloc_q <= alloc_q + CW'(1);
						idx_q <= alloc_q[IW-1:0];
						ok_q <= 1'b1;
					end
				end
				pjs_pkg::REQ_REMOVE: begin
					if (jidx_ext < alloc_q && used_q[jidx] && !(act_on_q && act_q == jidx)) begin
						used_q[jidx]  <= 1'b0;
						state_q[jidx] <= pjs_pkg::JS_PENDING;
						comp_q[jidx]  <= '0;
						idx_q <= jidx;
						ok_q <= 1'b1;
					end
				end
				pjs_pkg::REQ_START: begin
					if (mode_q != pjs_pkg::MODE_STOPPED) begin
						mode_q <= pjs_pkg::MODE_RUNNING;
						ok_q <= 1'b1;
					end
				end
				pjs_pkg::REQ_PAUSE: begin
					if (mode_q == pjs_pkg::MODE_RUNNING) begin
						mode_q <= pjs_pkg::MODE_HOLDING;
						ok_q <= 1'b1;
					end
				end
				pjs_pkg::REQ_RESUME: begin
					if (mode_q == pjs_pkg::MODE_HOLDING) begin
						mode_q <= pjs_pkg::MODE_RUNNING;
						ok_q <= 1'b1;
					end
				end
				pjs_pkg::REQ_STOP: begin
					mode_q <= pjs_pkg::MODE_STOPPED;
					ok_q <= 1'b1;
				end
				pjs_pkg::REQ_SKIP, pjs_pkg::REQ_ABORT: begin
					if (act_live) begin
						idx_q <= act_q;
						act_on_q <= 1'b0;
						ok_q <= 1'b1;
						if (req_q.req_type == pjs_pkg::REQ_ABORT) begin
							state_q[act_q] <= pjs_pkg::JS_FAULTED;
							mode_q <= pjs_pkg::MODE_HOLDING;
						end else begin
							state_q[act_q] <= pjs_pkg::JS_SKIPPED;
						end
					end
				end
				pjs_pkg::REQ_CLEAR: begin
					used_q <= '0;
					alloc_q <= '0;
					act_on_q <= 1'b0;
					act_q <= '0;
					mode_q <= pjs_pkg::MODE_IDLE;
					ok_q <= 1'b1;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						state_q[i] <= pjs_pkg::JS_PENDING;
						comp_q[i]  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.ok           <= ok_q;
			out_q.result_index <= 4'(idx_q);
			out_q.tick_event   <= ev_q;
			out_q.sched_state  <= mode_q;
			out_q.active_valid <= act_on_q;
			out_q.active_index <= act_on_q ? 4'(act_q) : 4'd0;
			out_q.job_total    <= 5'(alloc_q);
		end
	end

	assign out_data = out_q;

endmodule

// ----- rtl/pjs_checker.sv -----
// Port checker for the priority job scheduler, bound to the top level.
module pjs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input pjs_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_no_active_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.active_valid |-> out_data.active_index == 4'd0)
		else $error("active index without active job");

	a_event_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tick_event != pjs_pkg::EV_NONE |-> out_data.ok)
		else $error("tick event without ok");

endmodule

bind priority_job_scheduler pjs_checker u_pjs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
